FILE: sv/mdw_pkg.sv
// shared types and constants of the retention weight pipeline
// no dependencies; used by every module of the block but mdw_delay
package mdw_pkg;

    typedef enum logic [1:0] {
        STRAT_EXP = 2'd0,
        STRAT_LIN = 2'd1,
        STRAT_ACC = 2'd2,
        STRAT_ONE = 2'd3
    } strategy_t;

    typedef enum logic [1:0] {
        REG_STRATEGY   = 2'd0,
        REG_DECAY_RATE = 2'd1,
        REG_MIN_ACCESS = 2'd2
    } reg_index_t;

    localparam logic [31:0] DECAY_RATE_RST = 32'd167772;
    localparam logic [31:0] MIN_ACCESS_RST = 32'd1;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [31:0] LN2_Q32    = 32'hB17217F8;

    localparam int DIV_STEP_BITS = 4;
    localparam int PDIV_STAGES   = 64 / DIV_STEP_BITS;
    localparam int PROD_LAT      = 4 + PDIV_STAGES;

    localparam int KDIV_BITS   = 7;
    localparam int KDIV_FIRST  = 4;
    localparam int TAYLOR_LAST = 14;
    localparam int EXP_LAT     = 2 + 3 * (TAYLOR_LAST - 1) + 1;

    // floor(2^32 / n), indexed by n, for n from 2 to 14; entry 1 holds 2^32 - 1, entries 0 and 15 hold 0
    localparam logic [31:0] RECIP_Q32 [16] = '{
        32'd0,          32'hFFFFFFFF,   32'd2147483648, 32'd1431655765,
        32'd1073741824, 32'd858993459,  32'd715827882,  32'd613566756,
        32'd536870912,  32'd477218588,  32'd429496729,  32'd390451572,
        32'd357913941,  32'd330382099,  32'd306783378,  32'd0
    };

    typedef struct packed {
        logic        ge_one;
        logic        ge_max;
        logic [29:0] x;
    } decay_x_t;

    typedef struct packed {
        logic [31:0] r;
        logic [6:0]  k;
        logic        over;
        logic [34:0] acc;
    } exp_ctx_t;

endpackage

FILE: sv/mdw_delay.sv
// enable-gated delay line for payload that runs beside the main pipeline
// no package dependency
module mdw_delay #(
    parameter int W = 17,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] dl_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg[0] <= din;
            for (int i = 1; i < N; i++) begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    assign dout = dl_reg[N-1];

endmodule

FILE: sv/mdw_prod.sv
// age, decay product and pipelined division by 1e9, four quotient bits a stage
// depends on mdw_pkg
module mdw_prod (
    input  logic               aclk,
    input  logic               en,
    input  logic [63:0]        last_access_ns,
    input  logic [63:0]        now_ns,
    input  logic [31:0]        decay_rate,
    output mdw_pkg::decay_x_t  xo
);

    logic [63:0] age_reg;
    logic [63:0] p0_reg;
    logic [63:0] p1_reg;
    logic [31:0] hi_reg;
    logic [63:0] lo_reg;
    logic [32:0] mid;
    logic [29:0] rem_reg [mdw_pkg::PDIV_STAGES+1];
    logic [63:0] dvd_reg [mdw_pkg::PDIV_STAGES+1];
    logic        sat_reg [mdw_pkg::PDIV_STAGES+1];
    logic [63:0] q;

    assign mid = {1'b0, p0_reg[63:32]} + {1'b0, p1_reg[31:0]};

    always_ff @(posedge aclk) begin
        if (en) begin
            age_reg    <= now_ns - last_access_ns;
            p0_reg     <= 64'(age_reg[31:0]) * 64'(decay_rate);
            p1_reg     <= 64'(age_reg[63:32]) * 64'(decay_rate);
            hi_reg     <= p1_reg[63:32] + 32'(mid[32]);
            lo_reg     <= {mid[31:0], p0_reg[31:0]};
            sat_reg[0] <= hi_reg >= 32'(mdw_pkg::NS_PER_SEC);
            rem_reg[0] <= hi_reg[29:0];
            dvd_reg[0] <= lo_reg;
        end
    end

    for (genvar g = 0; g < mdw_pkg::PDIV_STAGES; g++) begin : g_div
        logic [29:0] rem_c;
        logic [63:0] dvd_c;
        logic [30:0] t;

        always_comb begin
            rem_c = rem_reg[g];
            dvd_c = dvd_reg[g];
            t     = '0;
            for (int i = 0; i < mdw_pkg::DIV_STEP_BITS; i++) begin
                t     = {rem_c, dvd_c[63]};
                dvd_c = {dvd_c[62:0], 1'b0};
                if (t >= {1'b0, mdw_pkg::NS_PER_SEC}) begin
                    rem_c    = 30'(t - {1'b0, mdw_pkg::NS_PER_SEC});
                    dvd_c[0] = 1'b1;
                end else begin
                    rem_c = t[29:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g+1] <= rem_c;
                dvd_reg[g+1] <= dvd_c;
                sat_reg[g+1] <= sat_reg[g];
            end
        end
    end

    assign q         = dvd_reg[mdw_pkg::PDIV_STAGES];
    assign xo.x      = q[29:0];
    assign xo.ge_max = sat_reg[mdw_pkg::PDIV_STAGES] | (|q[63:30]);
    assign xo.ge_one = sat_reg[mdw_pkg::PDIV_STAGES] | (|q[63:24]);

endmodule

FILE: sv/mdw_exp.sv
// exp(-x): range reduction by ln 2, Taylor series three stages a term, final shift
// depends on mdw_pkg
module mdw_exp #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      en,
    input  mdw_pkg::decay_x_t         xi,
    output logic [WEIGHT_FRAC_BITS:0] weight
);

    localparam int W  = WEIGHT_FRAC_BITS + 1;
    localparam int TL = mdw_pkg::TAYLOR_LAST;

    logic [31:0] kd_rem_reg;
    logic [6:0]  kd_q_reg;
    logic        kd_over_reg;
    logic [31:0] rem_a;
    logic [6:0]  q_a;
    logic [32:0] t_a;
    logic [31:0] rem_b;
    logic [6:0]  q_b;
    logic [32:0] t_b;

    logic [31:0]       term_reg  [1:TL-1];
    mdw_pkg::exp_ctx_t ctx_reg   [1:TL];
    logic [31:0]       v_a_reg   [2:TL];
    mdw_pkg::exp_ctx_t ctx_a_reg [2:TL];
    logic [31:0]       v_b_reg   [2:TL];
    logic [31:0]       qe_b_reg  [2:TL];
    mdw_pkg::exp_ctx_t ctx_b_reg [2:TL];

    logic [7:0]   sh;
    logic [33:0]  e;
    logic [34:0]  rnd;
    logic [W-1:0] w_nx;
    logic [W-1:0] weight_reg;

    always_comb begin
        rem_a = {1'b0, xi.x, 1'b0};
        q_a   = '0;
        t_a   = '0;
        for (int i = 0; i < mdw_pkg::KDIV_FIRST; i++) begin
            t_a = {rem_a, 1'b0};
            if (t_a >= {1'b0, mdw_pkg::LN2_Q32}) begin
                rem_a = 32'(t_a - {1'b0, mdw_pkg::LN2_Q32});
                q_a   = {q_a[5:0], 1'b1};
            end else begin
                rem_a = t_a[31:0];
                q_a   = {q_a[5:0], 1'b0};
            end
        end
    end

    always_comb begin
        rem_b = kd_rem_reg;
        q_b   = kd_q_reg;
        t_b   = '0;
        for (int i = mdw_pkg::KDIV_FIRST; i < mdw_pkg::KDIV_BITS; i++) begin
            t_b = {rem_b, 1'b0};
            if (t_b >= {1'b0, mdw_pkg::LN2_Q32}) begin
                rem_b = 32'(t_b - {1'b0, mdw_pkg::LN2_Q32});
                q_b   = {q_b[5:0], 1'b1};
            end else begin
                rem_b = t_b[31:0];
                q_b   = {q_b[5:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kd_rem_reg       <= rem_a;
            kd_q_reg         <= q_a;
            kd_over_reg      <= xi.ge_max;
            term_reg[1]      <= rem_b;
            ctx_reg[1].r     <= rem_b;
            ctx_reg[1].k     <= q_b;
            ctx_reg[1].over  <= kd_over_reg;
            ctx_reg[1].acc   <= 35'h1_0000_0000 - 35'(rem_b);
        end
    end

    for (genvar n = 2; n <= TL; n++) begin : g_term
        logic [63:0]       prod;
        logic [63:0]       qm;
        logic [35:0]       remv;
        logic [31:0]       term_nx;
        mdw_pkg::exp_ctx_t ctx_nx;

        assign prod = 64'(term_reg[n-1]) * 64'(ctx_reg[n-1].r);
        assign qm   = 64'(v_a_reg[n]) * 64'(mdw_pkg::RECIP_Q32[n]);
        assign remv = 36'(v_b_reg[n]) - 36'(qe_b_reg[n]) * 36'(n);

        always_comb begin
            term_nx = qe_b_reg[n] + 32'(remv >= 36'(n));
            ctx_nx  = ctx_b_reg[n];
            if ((n % 2) == 0) begin
                ctx_nx.acc = ctx_b_reg[n].acc + 35'(term_nx);
            end else begin
                ctx_nx.acc = ctx_b_reg[n].acc - 35'(term_nx);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_a_reg[n]   <= prod[63:32];
                ctx_a_reg[n] <= ctx_reg[n-1];
                qe_b_reg[n]  <= qm[63:32];
                v_b_reg[n]   <= v_a_reg[n];
                ctx_b_reg[n] <= ctx_a_reg[n];
                ctx_reg[n]   <= ctx_nx;
            end
        end

        if (n < TL) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    term_reg[n] <= term_nx;
                end
            end
        end
    end

    assign sh = 8'd32 + {1'b0, ctx_reg[TL].k} - 8'(WEIGHT_FRAC_BITS);
    assign e  = ctx_reg[TL].acc[33:0];

    always_comb begin
        rnd  = ({1'b0, e} + (35'd1 << (sh - 8'd1))) >> sh;
        w_nx = W'(rnd);
        if (ctx_reg[TL].over || sh >= 8'd34) begin
            w_nx = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            weight_reg <= w_nx;
        end
    end

    assign weight = weight_reg;

endmodule

FILE: sv/mdw_acc.sv
// access-count ratio: rounded count * 2^F / minimum by a restoring divider
// depends on mdw_pkg
module mdw_acc #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [31:0]               hit_count,
    input  logic [31:0]               min_hits,
    output logic [WEIGHT_FRAC_BITS:0] weight
);

    localparam int F      = WEIGHT_FRAC_BITS;
    localparam int DW     = 33 + F;
    localparam int STAGES = (F + mdw_pkg::DIV_STEP_BITS - 1) / mdw_pkg::DIV_STEP_BITS;

    logic [DW-1:0] dvd;
    logic [31:0]   rem_reg  [STAGES+1];
    logic [F-1:0]  q_reg    [STAGES+1];
    logic          zero_reg [STAGES+1];
    logic          full_reg [STAGES+1];

    assign dvd = DW'({hit_count, {F{1'b0}}}) + DW'(min_hits[31:1]);

    // a rounded quotient of 2^F also counts as full
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= dvd[DW-2:F];
            q_reg[0]    <= dvd[F-1:0];
            zero_reg[0] <= min_hits == 32'd0;
            full_reg[0] <= (hit_count >= min_hits) || (dvd[DW-1:F] >= {1'b0, min_hits});
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_div
        logic [31:0]  rem_c;
        logic [F-1:0] q_c;
        logic [32:0]  t;

        always_comb begin
            rem_c = rem_reg[g];
            q_c   = q_reg[g];
            t     = '0;
            for (int i = 0; i < mdw_pkg::DIV_STEP_BITS; i++) begin
                if (g * mdw_pkg::DIV_STEP_BITS + i < F) begin
                    t = {rem_c, q_c[F-1]};
                    if (t >= {1'b0, min_hits}) begin
                        rem_c = 32'(t - {1'b0, min_hits});
                        q_c   = {q_c[F-2:0], 1'b1};
                    end else begin
                        rem_c = t[31:0];
                        q_c   = {q_c[F-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g+1]  <= rem_c;
                q_reg[g+1]    <= q_c;
                zero_reg[g+1] <= zero_reg[g];
                full_reg[g+1] <= full_reg[g];
            end
        end
    end

    always_comb begin
        priority if (zero_reg[STAGES]) begin
            weight = '0;
        end else if (full_reg[STAGES]) begin
            weight = {1'b1, {F{1'b0}}};
        end else begin
            weight = {1'b0, q_reg[STAGES]};
        end
    end

endmodule

FILE: sv/memory_decay_weight.sv
// pipeline: the age, product and 16-stage division by 1e9 in mdw_prod, then the ln 2 reduction and the
// Taylor series to the x^14 term in mdw_exp; one item a cycle while the output buffer is not full
// a two-entry output buffer keeps s_tready high while one result waits; s_tready drops when both are full
// reset: synchronous active low, clears valid bits and the buffer count, restores register defaults
// depends on mdw_pkg, mdw_prod, mdw_exp, mdw_acc, mdw_delay
module memory_decay_weight #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // last_access_ns, now_ns, access count
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // weight
    output logic [((WEIGHT_FRAC_BITS + 8) / 8) * 8 - 1:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int W         = WEIGHT_FRAC_BITS + 1;
    localparam int OUT_W     = ((WEIGHT_FRAC_BITS + 8) / 8) * 8;
    localparam int TOTAL_LAT = mdw_pkg::PROD_LAT + mdw_pkg::EXP_LAT;
    localparam int ACC_LAT   = 1 + (WEIGHT_FRAC_BITS + mdw_pkg::DIV_STEP_BITS - 1)
                               / mdw_pkg::DIV_STEP_BITS;
    localparam int LIN_W     = 24 + WEIGHT_FRAC_BITS + 1;
    localparam logic [W-1:0] W_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

    mdw_pkg::strategy_t strategy_reg;
    logic [31:0]        decay_rate_reg;
    logic [31:0]        min_access_reg;

    logic                 en;
    logic [TOTAL_LAT-1:0] vld_reg;
    mdw_pkg::decay_x_t    xv;
    logic [LIN_W-1:0]     lin_sum;
    logic [W-1:0]         lin_w;
    logic [W-1:0]         lin_reg;
    logic [W-1:0]         lin_d;
    logic [W-1:0]         acc_w;
    logic [W-1:0]         acc_d;
    logic [W-1:0]         exp_w;
    logic [W-1:0]         w_out;

    logic         push;
    logic         pop;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic [W-1:0] buf0_reg;
    logic [W-1:0] buf0_next;
    logic [W-1:0] buf1_reg;
    logic [W-1:0] buf1_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strategy_reg   <= mdw_pkg::STRAT_EXP;
            decay_rate_reg <= mdw_pkg::DECAY_RATE_RST;
            min_access_reg <= mdw_pkg::MIN_ACCESS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mdw_pkg::REG_STRATEGY:   strategy_reg <= mdw_pkg::strategy_t'(cfg_wdata[1:0]);
                mdw_pkg::REG_DECAY_RATE: decay_rate_reg <= cfg_wdata;
                mdw_pkg::REG_MIN_ACCESS: min_access_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en       = cnt_reg != 2'd2;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_tvalid};
        end
    end

    mdw_prod u_prod (
        .aclk           (aclk),
        .en             (en),
        .last_access_ns (s_tdata[63:0]),
        .now_ns         (s_tdata[127:64]),
        .decay_rate     (decay_rate_reg),
        .xo             (xv)
    );

    mdw_exp #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_exp (
        .aclk   (aclk),
        .en     (en),
        .xi     (xv),
        .weight (exp_w)
    );

    // linear decay
    assign lin_sum = LIN_W'({xv.x[23:0], {WEIGHT_FRAC_BITS{1'b0}}}) + LIN_W'(24'h800000);
    assign lin_w   = xv.ge_one ? '0 : W_ONE - lin_sum[LIN_W-1:24];

    always_ff @(posedge aclk) begin
        if (en) begin
            lin_reg <= lin_w;
        end
    end

    mdw_delay #(
        .W (W),
        .N (TOTAL_LAT - mdw_pkg::PROD_LAT - 1)
    ) u_lin_dl (
        .aclk (aclk),
        .en   (en),
        .din  (lin_reg),
        .dout (lin_d)
    );

    mdw_acc #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_acc (
        .aclk      (aclk),
        .en        (en),
        .hit_count (s_tdata[159:128]),
        .min_hits  (min_access_reg),
        .weight    (acc_w)
    );

    mdw_delay #(
        .W (W),
        .N (TOTAL_LAT - ACC_LAT)
    ) u_acc_dl (
        .aclk (aclk),
        .en   (en),
        .din  (acc_w),
        .dout (acc_d)
    );

    always_comb begin
        unique case (strategy_reg)
            mdw_pkg::STRAT_EXP: w_out = exp_w;
            mdw_pkg::STRAT_LIN: w_out = lin_d;
            mdw_pkg::STRAT_ACC: w_out = acc_d;
            mdw_pkg::STRAT_ONE: w_out = W_ONE;
        endcase
    end

    // output buffer
    assign push     = en & vld_reg[TOTAL_LAT-1];
    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = OUT_W'(buf0_reg);

    always_comb begin
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        if (pop) begin
            buf0_next = (cnt_reg == 2'd2) ? buf1_reg : w_out;
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                buf0_next = w_out;
            end else begin
                buf1_next = w_out;
            end
        end
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push)
        else $error("item pushed into full output buffer");

    a_weight_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> buf0_reg <= W_ONE)
        else $error("weight above one");

    a_zero_min: assert property (@(posedge aclk) disable iff (!aresetn)
        push && strategy_reg == mdw_pkg::STRAT_ACC && min_access_reg == 32'd0
        |-> w_out == '0)
        else $error("access weight not zero for zero minimum");
`endif

endmodule
